FILE: hw/rtl/umep_pkg.sv
package umep_pkg;

    // Field widths
    localparam int CMD_W    = 3;
    localparam int CHAN_W   = 8;
    localparam int NUM_W    = 8;
    localparam int VAL_W    = 8;
    localparam int AMT_W    = 16;
    localparam int CIN_W    = 4;
    localparam int STAT_W   = 8;
    localparam int DATA_W   = 7;
    localparam int DZ_W     = 7;
    localparam int ENTRY_W  = 8;   // valid flag + last value
    localparam int CH_IDX_W = 4;   // channel index inside the status nibble
    localparam int BEND_W   = 14;
    localparam int WIDE_W   = 24;  // scratch delta * 256 fits here

    localparam int DEF_CHANNELS    = 16;
    localparam int DEF_CONTROLLERS = 128;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CC      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BEND    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NUDGE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SCRATCH = 3'd4;

    // USB-MIDI code index numbers
    localparam logic [CIN_W-1:0] CIN_NOTE_OFF = 4'h8;
    localparam logic [CIN_W-1:0] CIN_NOTE_ON  = 4'h9;
    localparam logic [CIN_W-1:0] CIN_CC       = 4'hB;
    localparam logic [CIN_W-1:0] CIN_BEND     = 4'hE;

    // Status type nibbles
    localparam logic [STAT_W-1:0] STAT_NOTE_OFF = 8'h80;
    localparam logic [STAT_W-1:0] STAT_NOTE_ON  = 8'h90;
    localparam logic [STAT_W-1:0] STAT_CC       = 8'hB0;
    localparam logic [STAT_W-1:0] STAT_BEND     = 8'hE0;

    // Nudge maps to the sustain controller
    localparam logic [DATA_W-1:0] NUDGE_CTL  = 7'd64;
    localparam logic [DATA_W-1:0] NUDGE_UP   = 7'd65;
    localparam logic [DATA_W-1:0] NUDGE_DOWN = 7'd63;

    localparam logic signed [WIDE_W-1:0] BEND_MIN = -24'sd8192;
    localparam logic signed [WIDE_W-1:0] BEND_MAX = 24'sd8191;
    localparam logic [BEND_W-1:0]        BEND_OFFSET = 14'd8192;

    typedef enum logic [1:0] {
        KIND_NONE,      // no packet
        KIND_PLAIN,     // packet sent as is
        KIND_TRACKED    // control change through the deadzone filter
    } t_kind;

    typedef struct packed {
        logic [CIN_W-1:0]  cable_index_code;
        logic [STAT_W-1:0] status_byte;
        logic [DATA_W-1:0] data_one;
        logic [DATA_W-1:0] data_two;
    } t_pkt;

    typedef struct packed {
        t_kind kind;
        t_pkt  pkt;
    } t_dec;

endpackage

FILE: hw/rtl/umep_evt_if.sv
interface umep_evt_if;
    logic                               valid;
    logic                               ready;
    logic [umep_pkg::CMD_W-1:0]         command;
    logic [umep_pkg::CHAN_W-1:0]        channel;
    logic [umep_pkg::NUM_W-1:0]         number;
    logic [umep_pkg::VAL_W-1:0]         value;
    logic signed [umep_pkg::AMT_W-1:0]  signed_amount;

    modport source (output valid, command, channel, number, value, signed_amount,
                    input ready);
    modport sink   (input valid, command, channel, number, value, signed_amount,
                    output ready);
endinterface

FILE: hw/rtl/umep_pkt_if.sv
interface umep_pkt_if;
    logic                          valid;
    logic                          ready;
    logic [umep_pkg::CIN_W-1:0]    cable_index_code;
    logic [umep_pkg::STAT_W-1:0]   status_byte;
    logic [umep_pkg::DATA_W-1:0]   data_one;
    logic [umep_pkg::DATA_W-1:0]   data_two;

    modport source (output valid, cable_index_code, status_byte, data_one, data_two,
                    input ready);
    modport sink   (input valid, cable_index_code, status_byte, data_one, data_two,
                    output ready);
endinterface

FILE: hw/rtl/usb_midi_event_packet_encoder.sv
// USB-MIDI event packet encoder. Each request on i_evt carries one MIDI event
// (control change, note, pitch bend, nudge or scratch) and yields zero or one
// four-byte event packet on o_pkt. Requests are taken one per clock unless
// stalled. A request is held in the stage 1 register, then its packet moves
// to the output register. Requests that produce nothing simply drop out of
// the pipe. Apart from the reset sweep below, the only stall is backpressure:
// when the output register holds an untaken packet and the filter stage holds
// another packet, i_evt.ready goes low. The last-sent control change values
// live in one CHANNELS*CONTROLLERS x 8 synchronous RAM (bit 7 = entry valid).
// After reset the block sweeps that RAM, one entry per clock, and i_evt.ready
// stays low until every entry (2048 with the defaults) is cleared. Deadzone
// writes are taken during the sweep. i_cfg_wr_data sets the deadzone and
// should only be written while the block is idle.
module usb_midi_event_packet_encoder #(
    parameter int CHANNELS    = umep_pkg::DEF_CHANNELS,
    parameter int CONTROLLERS = umep_pkg::DEF_CONTROLLERS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [umep_pkg::DZ_W-1:0]  i_cfg_wr_data,
    umep_evt_if.sink                   i_evt,
    umep_pkt_if.source                 o_pkt
);

    localparam int DEPTH = CHANNELS * CONTROLLERS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ---------------------------------------------------------------
    // Request decode (stage 0): packet fields, kind and table address
    // ---------------------------------------------------------------
    umep_pkg::t_dec dec;
    logic [AW-1:0]  dec_addr;

    umep_decode #(
        .CHANNELS    (CHANNELS),
        .CONTROLLERS (CONTROLLERS),
        .AW          (AW)
    ) u_decode (
        .i_command       (i_evt.command),
        .i_channel       (i_evt.channel),
        .i_number        (i_evt.number),
        .i_value         (i_evt.value),
        .i_signed_amount (i_evt.signed_amount),
        .o_dec           (dec),
        .o_addr          (dec_addr)
    );

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    logic                            r_clr_active;
    logic [AW-1:0]                   r_clr_addr;
    logic [umep_pkg::DZ_W-1:0]       r_deadzone;

    logic                            r_s1_valid;
    umep_pkg::t_dec                  r_s1_dec;
    logic [AW-1:0]                   r_s1_addr;
    logic                            r_byp_hit;
    logic [umep_pkg::ENTRY_W-1:0]    r_byp_data;

    logic                            r_out_valid;
    umep_pkg::t_pkt                  r_out_pkt;

    // RAM side
    logic                            mem_we;
    logic [AW-1:0]                   mem_wa;
    logic [umep_pkg::ENTRY_W-1:0]    mem_wd;
    logic [umep_pkg::ENTRY_W-1:0]    mem_rd;

    // Filter stage
    logic [umep_pkg::ENTRY_W-1:0]    entry;
    logic [umep_pkg::DATA_W-1:0]     last_val;
    logic [umep_pkg::DATA_W-1:0]     new_val;
    logic [umep_pkg::DATA_W-1:0]     diff;
    logic                            drop;
    logic                            s1_emit;
    logic                            s1_adv;
    logic                            out_free;
    logic                            wr_norm;
    logic                            in_ready;
    logic                            accept;

    // ---------------------------------------------------------------
    // Filter stage (stage 1): read data arrives in the cycle after accept.
    // If the previous request wrote the same entry on the accept edge,
    // the RAM returned the old value, so the forwarded copy wins.
    // ---------------------------------------------------------------
    assign entry    = r_byp_hit ? r_byp_data : mem_rd;
    assign last_val = entry[umep_pkg::DATA_W-1:0];
    assign new_val  = r_s1_dec.pkt.data_two;
    assign diff     = (new_val > last_val) ? (new_val - last_val) : (last_val - new_val);
    assign drop     = (r_s1_dec.kind == umep_pkg::KIND_TRACKED) &&
                      entry[umep_pkg::ENTRY_W-1] && (diff < r_deadzone);

    assign s1_emit  = r_s1_valid && (r_s1_dec.kind != umep_pkg::KIND_NONE) && !drop;
    assign out_free = !r_out_valid || o_pkt.ready;
    assign s1_adv   = !s1_emit || out_free;
    assign wr_norm  = r_s1_valid && (r_s1_dec.kind == umep_pkg::KIND_TRACKED) &&
                      !drop && out_free;

    assign in_ready    = !r_clr_active && (!r_s1_valid || s1_adv);
    assign accept      = i_evt.valid && in_ready;
    assign i_evt.ready = in_ready;

    // Write port: clearing sweep after reset, then table updates
    assign mem_we = r_clr_active || wr_norm;
    assign mem_wa = r_clr_active ? r_clr_addr : r_s1_addr;
    assign mem_wd = r_clr_active ? '0 : {1'b1, new_val};

    umep_cc_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cc_mem (
        .i_clk (i_clk),
        .i_we  (mem_we),
        .i_wa  (mem_wa),
        .i_wd  (mem_wd),
        .i_re  (accept),
        .i_ra  (dec_addr),
        .o_rd  (mem_rd)
    );

    // ---------------------------------------------------------------
    // Clearing sweep and deadzone register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == AW'(DEPTH - 1))
                r_clr_active <= 1'b0;
            else
                r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= '0;
        end else if (i_cfg_wr_en) begin
            r_deadzone <= i_cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1 register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_dec   <= dec;
            r_s1_addr  <= dec_addr;
            r_byp_hit  <= wr_norm && (r_s1_addr == dec_addr);
            r_byp_data <= {1'b1, new_val};
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_emit && s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_pkt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_emit && s1_adv)
            r_out_pkt <= r_s1_dec.pkt;
    end

    assign o_pkt.valid            = r_out_valid;
    assign o_pkt.cable_index_code = r_out_pkt.cable_index_code;
    assign o_pkt.status_byte      = r_out_pkt.status_byte;
    assign o_pkt.data_one         = r_out_pkt.data_one;
    assign o_pkt.data_two         = r_out_pkt.data_two;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // Same-entry write on an accept edge must be forwarded
    a_fwd_on_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && wr_norm && (r_s1_addr == dec_addr)) |=> r_byp_hit)
        else $error("table collision not forwarded");

    // Sweep ends only after the last entry is written
    a_sweep_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_active) |-> ($past(r_clr_addr) == AW'(DEPTH - 1)))
        else $error("clearing sweep ended early");

    // A filtered drop needs a nonzero deadzone
    a_drop_needs_deadzone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && drop) |-> (r_deadzone != '0))
        else $error("control change dropped with zero deadzone");

    // A stored value is the one that goes out
    a_store_matches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_norm && !r_clr_active) |=>
            (r_out_valid && (r_out_pkt.data_two == $past(mem_wd[umep_pkg::DATA_W-1:0]))))
        else $error("stored value differs from sent value");

endmodule

FILE: hw/rtl/umep_decode.sv
module umep_decode #(
    parameter int CHANNELS    = umep_pkg::DEF_CHANNELS,
    parameter int CONTROLLERS = umep_pkg::DEF_CONTROLLERS,
    parameter int AW          = 11
) (
    input  logic [umep_pkg::CMD_W-1:0]        i_command,
    input  logic [umep_pkg::CHAN_W-1:0]       i_channel,
    input  logic [umep_pkg::NUM_W-1:0]        i_number,
    input  logic [umep_pkg::VAL_W-1:0]        i_value,
    input  logic signed [umep_pkg::AMT_W-1:0] i_signed_amount,
    output umep_pkg::t_dec                    o_dec,
    output logic [AW-1:0]                     o_addr
);

    logic                                  ch_ok;
    logic [umep_pkg::CHAN_W-1:0]           ch_m1;
    logic [umep_pkg::CH_IDX_W-1:0]         ch_idx;
    logic [umep_pkg::DATA_W-1:0]           cc_ctl;
    logic [umep_pkg::DATA_W-1:0]           cc_val;
    logic                                  cc_in_table;
    logic signed [umep_pkg::WIDE_W-1:0]    bend_wide;
    logic signed [umep_pkg::WIDE_W-1:0]    bend_sat;
    logic [umep_pkg::BEND_W-1:0]           bend_u;

    assign ch_ok  = (i_channel != '0) && (i_channel <= umep_pkg::CHAN_W'(CHANNELS));
    assign ch_m1  = i_channel - umep_pkg::CHAN_W'(1);
    assign ch_idx = ch_m1[umep_pkg::CH_IDX_W-1:0];

    // Nudge rides the control change path on the sustain controller
    always_comb begin
        if (i_command == umep_pkg::CMD_NUDGE) begin
            cc_ctl = umep_pkg::NUDGE_CTL;
            cc_val = i_signed_amount[umep_pkg::AMT_W-1] ? umep_pkg::NUDGE_DOWN
                                                         : umep_pkg::NUDGE_UP;
        end else begin
            cc_ctl = i_number[umep_pkg::DATA_W-1:0];
            cc_val = i_value[umep_pkg::DATA_W-1:0];
        end
    end

    assign cc_in_table = {1'b0, cc_ctl} < (umep_pkg::DATA_W + 1)'(CONTROLLERS);
    assign o_addr      = AW'(ch_idx) * AW'(CONTROLLERS) + AW'(cc_ctl);

    // Scratch scales by 256; both bend kinds saturate to the 14-bit range
    always_comb begin
        if (i_command == umep_pkg::CMD_SCRATCH)
            bend_wide = {i_signed_amount, 8'h00};
        else
            bend_wide = umep_pkg::WIDE_W'(i_signed_amount);
        if (bend_wide < umep_pkg::BEND_MIN)
            bend_sat = umep_pkg::BEND_MIN;
        else if (bend_wide > umep_pkg::BEND_MAX)
            bend_sat = umep_pkg::BEND_MAX;
        else
            bend_sat = bend_wide;
    end

    assign bend_u = bend_sat[umep_pkg::BEND_W-1:0] + umep_pkg::BEND_OFFSET;

    always_comb begin
        o_dec.kind                 = umep_pkg::KIND_NONE;
        o_dec.pkt.cable_index_code = umep_pkg::CIN_CC;
        o_dec.pkt.status_byte      = umep_pkg::STAT_CC | umep_pkg::STAT_W'(ch_idx);
        o_dec.pkt.data_one         = cc_ctl;
        o_dec.pkt.data_two         = cc_val;
        unique case (i_command)
            umep_pkg::CMD_CC, umep_pkg::CMD_NUDGE: begin
                if (ch_ok && !(i_command == umep_pkg::CMD_NUDGE && i_signed_amount == '0))
                    o_dec.kind = cc_in_table ? umep_pkg::KIND_TRACKED : umep_pkg::KIND_PLAIN;
            end
            umep_pkg::CMD_NOTE: begin
                if (ch_ok)
                    o_dec.kind = umep_pkg::KIND_PLAIN;
                o_dec.pkt.data_one = i_number[umep_pkg::DATA_W-1:0];
                if (i_value != '0) begin
                    o_dec.pkt.cable_index_code = umep_pkg::CIN_NOTE_ON;
                    o_dec.pkt.status_byte = umep_pkg::STAT_NOTE_ON | umep_pkg::STAT_W'(ch_idx);
                    o_dec.pkt.data_two    = i_value[umep_pkg::DATA_W-1:0];
                end else begin
                    o_dec.pkt.cable_index_code = umep_pkg::CIN_NOTE_OFF;
                    o_dec.pkt.status_byte = umep_pkg::STAT_NOTE_OFF | umep_pkg::STAT_W'(ch_idx);
                    o_dec.pkt.data_two    = '0;
                end
            end
            umep_pkg::CMD_BEND, umep_pkg::CMD_SCRATCH: begin
                if (ch_ok)
                    o_dec.kind = umep_pkg::KIND_PLAIN;
                o_dec.pkt.cable_index_code = umep_pkg::CIN_BEND;
                o_dec.pkt.status_byte = umep_pkg::STAT_BEND | umep_pkg::STAT_W'(ch_idx);
                o_dec.pkt.data_one    = bend_u[umep_pkg::DATA_W-1:0];
                o_dec.pkt.data_two    = bend_u[umep_pkg::BEND_W-1:umep_pkg::DATA_W];
            end
            default: begin
                o_dec.kind = umep_pkg::KIND_NONE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/umep_cc_mem.sv
module umep_cc_mem #(
    parameter int DEPTH = umep_pkg::DEF_CHANNELS * umep_pkg::DEF_CONTROLLERS,
    parameter int AW    = 11
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_wa,
    input  logic [umep_pkg::ENTRY_W-1:0]  i_wd,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_ra,
    output logic [umep_pkg::ENTRY_W-1:0]  o_rd
);

    logic [umep_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [umep_pkg::ENTRY_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we)
            mem[i_wa] <= i_wd;
    end

    // Read-old on a same-address collision; caller forwards
    always_ff @(posedge i_clk) begin
        if (i_re)
            r_rd <= mem[i_ra];
    end

    assign o_rd = r_rd;

endmodule

FILE: tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import umep_pkg::*;

    // Unused command codes: the block drops these requests.
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    localparam int TABLE_DEPTH   = DEF_CHANNELS * DEF_CONTROLLERS;
    localparam int SCRATCH_SCALE = 256;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 235;    // useful requests per random phase
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int LIMIT_CYCLES  = 400000;

    typedef struct {
        logic [CMD_W-1:0]        command;
        logic [CHAN_W-1:0]       channel;
        logic [NUM_W-1:0]        number;
        logic [VAL_W-1:0]        value;
        logic signed [AMT_W-1:0] amount;
    } midi_event_t;

    // Directed rows either carry a request or a deadzone write.
    typedef enum {ROW_EVENT, ROW_DEADZONE} row_kind_e;
    // OUT_MODEL: ask the predictor; OUT_NONE / OUT_TYPED: result written in the row.
    typedef enum {OUT_MODEL, OUT_NONE, OUT_TYPED} row_out_e;

    typedef struct {
        row_kind_e   kind;
        midi_event_t ev;
        row_out_e    out;
        t_pkt        pkt;
        logic [DZ_W-1:0] dz;
    } directed_row_t;

    localparam t_pkt NO_PKT = '0;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [DZ_W-1:0] i_cfg_wr_data;

    umep_evt_if evt_bus ();
    umep_pkt_if pkt_bus ();

    usb_midi_event_packet_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_evt         (evt_bus),
        .o_pkt         (pkt_bus)
    );

    // Predictor state: last CC value sent per channel/controller (bit 7 = valid)
    // and the deadzone currently programmed.
    logic [ENTRY_W-1:0] last_sent [TABLE_DEPTH];
    logic [DZ_W-1:0]    deadzone;

    t_pkt pending_pkts [$];    // packets still owed by the block, oldest first
    int   errors;
    int   cycles;
    bit   hold_req;            // sender asks receiver for a long hold-off
    int   burst_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit channel_in_range(input logic [CHAN_W-1:0] ch);
        return ch >= 1 && ch <= DEF_CHANNELS;
    endfunction

    // Control change through the deadzone filter; updates the last-sent table.
    function automatic bit cc_packet(input logic [CHAN_W-1:0] ch, input logic [DATA_W-1:0] ctl,
                                     input logic [DATA_W-1:0] val, output t_pkt pkt);
        logic [CH_IDX_W-1:0] nib;
        int slot;
        int diff;
        pkt = NO_PKT;
        if (!channel_in_range(ch))
            return 1'b0;
        nib = CH_IDX_W'(ch - 8'd1);
        if (ctl < DEF_CONTROLLERS) begin
            slot = int'(nib) * DEF_CONTROLLERS + int'(ctl);
            if (last_sent[slot][ENTRY_W-1]) begin
                diff = int'(val) - int'(last_sent[slot][DATA_W-1:0]);
                if (diff < 0)
                    diff = -diff;
                if (diff < int'(deadzone))
                    return 1'b0;
            end
            last_sent[slot] = {1'b1, val};
        end
        pkt = '{CIN_CC, STAT_CC | {4'h0, nib}, ctl, val};
        return 1'b1;
    endfunction

    // Pitch bend: clip to the 14-bit range, then offset to unsigned.
    function automatic bit bend_packet(input logic [CHAN_W-1:0] ch, input int amount,
                                       output t_pkt pkt);
        int clipped;
        logic [BEND_W-1:0] code;
        pkt = NO_PKT;
        if (!channel_in_range(ch))
            return 1'b0;
        clipped = amount;
        if (clipped < int'(BEND_MIN))
            clipped = int'(BEND_MIN);
        if (clipped > int'(BEND_MAX))
            clipped = int'(BEND_MAX);
        code = BEND_W'(clipped) + BEND_OFFSET;
        pkt = '{CIN_BEND, STAT_BEND | {4'h0, CH_IDX_W'(ch - 8'd1)},
                code[DATA_W-1:0], code[BEND_W-1:DATA_W]};
        return 1'b1;
    endfunction

    function automatic bit encode_event(input midi_event_t ev, output t_pkt pkt);
        logic [CH_IDX_W-1:0] nib;
        pkt = NO_PKT;
        nib = CH_IDX_W'(ev.channel - 8'd1);
        case (ev.command)
            CMD_CC: begin
                return cc_packet(ev.channel, ev.number[DATA_W-1:0], ev.value[DATA_W-1:0], pkt);
            end
            CMD_NOTE: begin
                if (!channel_in_range(ev.channel))
                    return 1'b0;
                // full 8-bit velocity decides on/off, only low 7 bits are sent
                if (ev.value != 0)
                    pkt = '{CIN_NOTE_ON, STAT_NOTE_ON | {4'h0, nib},
                            ev.number[DATA_W-1:0], ev.value[DATA_W-1:0]};
                else
                    pkt = '{CIN_NOTE_OFF, STAT_NOTE_OFF | {4'h0, nib},
                            ev.number[DATA_W-1:0], 7'd0};
                return 1'b1;
            end
            CMD_BEND: begin
                return bend_packet(ev.channel, int'(ev.amount), pkt);
            end
            CMD_NUDGE: begin
                if (ev.amount == 0)
                    return 1'b0;
                return cc_packet(ev.channel, NUDGE_CTL,
                                 (ev.amount > 0) ? NUDGE_UP : NUDGE_DOWN, pkt);
            end
            CMD_SCRATCH: begin
                return bend_packet(ev.channel, int'(ev.amount) * SCRATCH_SCALE, pkt);
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Present one request and hold it until accepted; queue what it owes.
    task automatic offer_request(input midi_event_t ev, input row_out_e how, input t_pkt typed);
        t_pkt pkt;
        bit   owed;
        @(negedge i_clk);
        evt_bus.valid         <= 1'b1;
        evt_bus.command       <= ev.command;
        evt_bus.channel       <= ev.channel;
        evt_bus.number        <= ev.number;
        evt_bus.value         <= ev.value;
        evt_bus.signed_amount <= ev.amount;
        @(posedge i_clk);
        while (!evt_bus.ready)
            @(posedge i_clk);
        // predictor always runs so the CC table tracks the block
        owed = encode_event(ev, pkt);
        if (how == OUT_TYPED)
            pending_pkts.push_back(typed);
        else if (how == OUT_MODEL && owed)
            pending_pkts.push_back(pkt);
    endtask

    // Bursts of random length, random gaps between them.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            evt_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            // one in four bursts is long, so stretches without gaps occur
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // Deadzone writes only with the block drained.
    task automatic set_deadzone(input logic [DZ_W-1:0] dz);
        @(negedge i_clk);
        evt_bus.valid <= 1'b0;
        while (pending_pkts.size() != 0)
            @(posedge i_clk);
        // dropped requests may still be in the pipe
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= dz;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        deadzone = dz;
    endtask

    function automatic directed_row_t ev_row(input logic [CMD_W-1:0] c,
                                             input logic [CHAN_W-1:0] ch,
                                             input logic [NUM_W-1:0] n,
                                             input logic [VAL_W-1:0] v,
                                             input logic signed [AMT_W-1:0] a,
                                             input row_out_e o, input t_pkt p);
        directed_row_t r;
        r.kind = ROW_EVENT;
        r.ev   = '{c, ch, n, v, a};
        r.out  = o;
        r.pkt  = p;
        r.dz   = '0;
        return r;
    endfunction

    function automatic directed_row_t dz_row(input logic [DZ_W-1:0] dz);
        directed_row_t r;
        r = ev_row(CMD_CC, 8'd0, 8'd0, 8'd0, 16'sd0, OUT_NONE, NO_PKT);
        r.kind = ROW_DEADZONE;
        r.dz   = dz;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random phases, drain
    // ------------------------------------------------------------------
    initial begin
        directed_row_t rows [$];
        midi_event_t   ev;
        int            phase_dz [PHASES];
        int            useful;
        int            tmp;
        bit            noise;

        i_rst_n               = 1'b0;
        i_cfg_wr_en           = 1'b0;
        i_cfg_wr_data         = '0;
        evt_bus.valid         = 1'b0;
        evt_bus.command       = '0;
        evt_bus.channel       = '0;
        evt_bus.number        = '0;
        evt_bus.value         = '0;
        evt_bus.signed_amount = '0;
        errors     = 0;
        hold_req   = 1'b0;
        burst_left = 0;
        deadzone   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            last_sent[i] = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes, every command, and the corner cases: channel out of
        // range, spare commands, 8-bit velocity, bend clipping, zero nudge and
        // nudge going through the deadzone filter.
        rows.push_back(dz_row(7'd0));
        rows.push_back(ev_row(CMD_CC, 8'd1, 8'h00, 8'h00, 16'sd0, OUT_TYPED,
                              '{CIN_CC, STAT_CC, 7'h00, 7'h00}));
        rows.push_back(ev_row(CMD_CC, 8'd16, 8'hFF, 8'hFF, 16'sd0, OUT_TYPED,
                              '{CIN_CC, STAT_CC | 8'h0F, 7'h7F, 7'h7F}));
        rows.push_back(ev_row(CMD_CC, 8'd0, 8'h10, 8'h20, 16'sd0, OUT_NONE, NO_PKT));
        rows.push_back(ev_row(CMD_CC, 8'd17, 8'h10, 8'h20, 16'sd0, OUT_NONE, NO_PKT));
        rows.push_back(ev_row(CMD_NOTE, 8'd1, 8'h80, 8'h00, 16'sd0, OUT_TYPED,
                              '{CIN_NOTE_OFF, STAT_NOTE_OFF, 7'h00, 7'h00}));
        rows.push_back(ev_row(CMD_NOTE, 8'd16, 8'h7F, 8'h80, 16'sd0, OUT_TYPED,
                              '{CIN_NOTE_ON, STAT_NOTE_ON | 8'h0F, 7'h7F, 7'h00}));
        rows.push_back(ev_row(CMD_NOTE, 8'd5, 8'h3C, 8'hFF, 16'sd0, OUT_MODEL, NO_PKT));
        rows.push_back(ev_row(CMD_BEND, 8'd1, 8'h00, 8'h00, 16'sh8000, OUT_TYPED,
                              '{CIN_BEND, STAT_BEND, 7'h00, 7'h00}));
        rows.push_back(ev_row(CMD_BEND, 8'd16, 8'h00, 8'h00, 16'sh7FFF, OUT_TYPED,
                              '{CIN_BEND, STAT_BEND | 8'h0F, 7'h7F, 7'h7F}));
        rows.push_back(ev_row(CMD_BEND, 8'd3, 8'hFF, 8'hFF, 16'sd0, OUT_TYPED,
                              '{CIN_BEND, STAT_BEND | 8'h02, 7'h00, 7'h40}));
        rows.push_back(ev_row(CMD_BEND, 8'd7, 8'h00, 8'h00, -16'sd8193, OUT_MODEL, NO_PKT));
        rows.push_back(ev_row(CMD_NUDGE, 8'd2, 8'h00, 8'h00, 16'sd0, OUT_NONE, NO_PKT));
        rows.push_back(ev_row(CMD_NUDGE, 8'd2, 8'h00, 8'h00, 16'sd1, OUT_TYPED,
                              '{CIN_CC, STAT_CC | 8'h01, NUDGE_CTL, NUDGE_UP}));
        rows.push_back(ev_row(CMD_NUDGE, 8'd2, 8'h00, 8'h00, 16'sh8000, OUT_MODEL, NO_PKT));
        rows.push_back(ev_row(CMD_SCRATCH, 8'd4, 8'h00, 8'h00, 16'sd31, OUT_MODEL, NO_PKT));
        rows.push_back(ev_row(CMD_SCRATCH, 8'd4, 8'h00, 8'h00, 16'sd32, OUT_MODEL, NO_PKT));
        rows.push_back(ev_row(CMD_SCRATCH, 8'd4, 8'h00, 8'h00, 16'sh8000, OUT_TYPED,
                              '{CIN_BEND, STAT_BEND | 8'h03, 7'h00, 7'h00}));
        rows.push_back(ev_row(CMD_SPARE_FIRST, 8'd1, 8'h01, 8'h01, 16'sd1, OUT_NONE, NO_PKT));
        rows.push_back(ev_row(CMD_SPARE_LAST, 8'd1, 8'h01, 8'h01, 16'sd1, OUT_NONE, NO_PKT));
        // widest deadzone: near values are dropped, empty slots still pass
        rows.push_back(dz_row(7'd127));
        rows.push_back(ev_row(CMD_CC, 8'd1, 8'h00, 8'h7F, 16'sd0, OUT_MODEL, NO_PKT));
        rows.push_back(ev_row(CMD_CC, 8'd1, 8'h00, 8'h01, 16'sd0, OUT_MODEL, NO_PKT));
        rows.push_back(ev_row(CMD_CC, 8'd9, 8'h33, 8'h05, 16'sd0, OUT_MODEL, NO_PKT));
        rows.push_back(ev_row(CMD_NUDGE, 8'd2, 8'h00, 8'h00, 16'sd5, OUT_MODEL, NO_PKT));
        // difference exactly at the deadzone passes, below it drops
        rows.push_back(dz_row(7'd3));
        rows.push_back(ev_row(CMD_NUDGE, 8'd2, 8'h00, 8'h00, -16'sd1, OUT_MODEL, NO_PKT));
        rows.push_back(ev_row(CMD_CC, 8'd1, 8'h80, 8'hFC, 16'sd0, OUT_MODEL, NO_PKT));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_DEADZONE) begin
                set_deadzone(rows[i].dz);
            end else begin
                offer_request(rows[i].ev, rows[i].out, rows[i].pkt);
                pace_sender();
            end
        end

        // Random phases, each under its own deadzone; extremes included.
        phase_dz[0] = 0;
        phase_dz[1] = 127;
        phase_dz[2] = 1;
        phase_dz[3] = $urandom_range(2, 12);
        phase_dz[4] = $urandom_range(0, 127);

        for (int p = 0; p < PHASES; p++) begin
            set_deadzone(DZ_W'(phase_dz[p]));
            // long receiver hold-off while requests keep coming
            if (p == 0 || p == 3)
                hold_req = 1'b1;
            useful = 0;
            while (useful < PHASE_ITEMS) begin
                noise = 1'b0;
                // mostly low channels so CC slots are revisited
                ev.channel = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 4))
                                                         : 8'($urandom_range(1, DEF_CHANNELS));
                tmp = $urandom_range(0, 99);
                if (tmp < 40)
                    ev.command = CMD_CC;
                else if (tmp < 55)
                    ev.command = CMD_NOTE;
                else if (tmp < 70)
                    ev.command = CMD_BEND;
                else if (tmp < 85)
                    ev.command = CMD_NUDGE;
                else
                    ev.command = CMD_SCRATCH;

                // a dozen controllers per channel, top bit random for the mask
                ev.number = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                        : {1'($urandom), 7'($urandom_range(0, 11))};
                case ($urandom_range(0, 3))
                    0: ev.value = {1'($urandom), 7'($urandom_range(58, 70))};
                    1: ev.value = '0;
                    default: ev.value = 8'($urandom);
                endcase
                case ($urandom_range(0, 4))
                    0: ev.amount = AMT_W'($urandom);
                    1: ev.amount = AMT_W'(int'($urandom_range(0, 80)) - 40);
                    2: ev.amount = '0;
                    3: begin
                        // around the bend clip points
                        tmp = $urandom_range(8185, 8199);
                        ev.amount = ($urandom_range(0, 1) == 0) ? AMT_W'(tmp) : AMT_W'(-tmp);
                    end
                    default: begin
                        // scratch deltas around the clip points
                        tmp = $urandom_range(28, 36);
                        ev.amount = ($urandom_range(0, 1) == 0) ? AMT_W'(tmp) : AMT_W'(-tmp);
                    end
                endcase

                if ($urandom_range(0, 99) < 12) begin
                    noise = 1'b1;
                    if ($urandom_range(0, 1) == 0)
                        ev.channel = ($urandom_range(0, 1) == 0)
                                   ? 8'd0 : 8'($urandom_range(DEF_CHANNELS + 1, 255));
                    else
                        ev.command = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
                end

                offer_request(ev, OUT_MODEL, NO_PKT);
                pace_sender();
                if (!noise)
                    useful++;
            end
        end

        // drain: everything owed must arrive, then a margin for stragglers
        @(negedge i_clk);
        evt_bus.valid <= 1'b0;
        while (pending_pkts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: segments of always-ready, coin-flip, fixed pattern and
    // mostly-stalled; a long hold-off when the sender asks for one.
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int seg_len;
        int tick;

        pkt_bus.ready = 1'b0;
        tick = 0;
        forever begin
            if (hold_req) begin
                @(negedge i_clk);
                pkt_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(16, 96);
            repeat (seg_len) begin
                @(negedge i_clk);
                tick++;
                case (mode)
                    0: pkt_bus.ready <= 1'b1;
                    1: pkt_bus.ready <= 1'($urandom);
                    2: pkt_bus.ready <= (tick % 5) < 3;
                    default: pkt_bus.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Packet checker
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_pkt want;
        if (i_rst_n && pkt_bus.valid && pkt_bus.ready) begin
            if (pending_pkts.size() == 0) begin
                errors++;
                $display("%0t: unexpected packet, expected none, actual %h %h %h %h", $time,
                         pkt_bus.cable_index_code, pkt_bus.status_byte,
                         pkt_bus.data_one, pkt_bus.data_two);
            end else begin
                want = pending_pkts.pop_front();
                check_field("cable_index_code", want.cable_index_code, pkt_bus.cable_index_code);
                check_field("status_byte", want.status_byte, pkt_bus.status_byte);
                check_field("data_one", want.data_one, pkt_bus.data_one);
                check_field("data_two", want.data_two, pkt_bus.data_two);
            end
        end
    end

    // Watchdog; the reset sweep and all stalls fit well inside the limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d packets outstanding", $time, pending_pkts.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial cycles = 0;

endmodule
